@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check on the rising edge, disabled during reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication check, disabled during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ hw/rtl/mhc_pkg.sv @@
// Package for the magnetometer heading calibrator.
// Holds commands, payload types, the CORDIC arctangent table and fixed constants.
`default_nettype none
package mhc_pkg;
    localparam logic [1:0] CMD_CAL = 2'd0;
    localparam logic [1:0] CMD_REF = 2'd1;
    localparam logic [1:0] CMD_HDG = 2'd2;
    localparam int TABLE_LEN = 24;
    localparam logic signed [31:0] DEG90_FINE = 32'sd2949120;
    localparam logic [15:0] FULL_TURN = 16'd46080;
    localparam logic [19:0] SPAN_Q8 = 20'd523776;   // 2046 * 256
    localparam logic signed [31:0] MID_Q8 = 32'sd261888; // 1023 * 256

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] reading_x;
        logic signed [15:0] reading_y;
        logic signed [15:0] reading_z;
        logic               data_ready;
        logic               field_overflow;
    } t_req;

    typedef struct packed {
        logic [15:0] heading;
        logic        sample_taken;
        logic        div_fault;
    } t_rsp;

    // queued job for the back part
    typedef struct packed {
        logic [1:0]         cmd;
        logic               taken;
        logic               fault;
        logic signed [36:0] num_x;   // (s - min) * 2046 * 256
        logic signed [36:0] num_y;
        logic [16:0]        rng_x;
        logic [16:0]        rng_y;
    } t_job;

    function automatic logic signed [31:0] atan_fine(input logic [4:0] i);
        case (i)
            5'd0: atan_fine = 32'sd1474560;  5'd1: atan_fine = 32'sd870484;
            5'd2: atan_fine = 32'sd459940;   5'd3: atan_fine = 32'sd233473;
            5'd4: atan_fine = 32'sd117189;   5'd5: atan_fine = 32'sd58652;
            5'd6: atan_fine = 32'sd29333;    5'd7: atan_fine = 32'sd14667;
            5'd8: atan_fine = 32'sd7334;     5'd9: atan_fine = 32'sd3667;
            5'd10: atan_fine = 32'sd1833;    5'd11: atan_fine = 32'sd917;
            5'd12: atan_fine = 32'sd458;     5'd13: atan_fine = 32'sd229;
            5'd14: atan_fine = 32'sd115;     5'd15: atan_fine = 32'sd57;
            5'd16: atan_fine = 32'sd29;      5'd17: atan_fine = 32'sd14;
            5'd18: atan_fine = 32'sd7;       5'd19: atan_fine = 32'sd4;
            5'd20: atan_fine = 32'sd2;       5'd21: atan_fine = 32'sd1;
            default: atan_fine = 32'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/mhc_stream_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface mhc_stream_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mhc_front.sv @@
// Front part: scales and keeps the sample, tracks min/max, builds heading jobs.
// Depends on mhc_pkg and mhc_stream_if.
`default_nettype none
module mhc_front import mhc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    mhc_stream_if.sink      s_req,
    output logic            o_job_valid,
    input  wire logic       i_job_ready,
    output t_job            o_job
);
    logic [7:0] r_adj [3];
    logic signed [15:0] r_kept [3];
    logic signed [15:0] r_max [3];
    logic signed [15:0] r_min [3];
    logic r_vld, r_pend;
    t_job r_job;
    logic [1:0] r_cmd;
    logic r_tk;

    // stage 1: multiply and keep (registered), stage 2: window and job
    logic signed [15:0] raw [3];
    logic signed [15:0] n_sc [3];
    logic signed [25:0] prod [3];
    logic signed [25:0] quo [3];
    logic signed [16:0] rng [2];
    logic signed [16:0] off [2];
    logic signed [36:0] numw [2];
    logic take;

    assign raw[0] = s_req.data.reading_x;
    assign raw[1] = s_req.data.reading_y;
    assign raw[2] = s_req.data.reading_z;
    assign take = s_req.data.data_ready & ~s_req.data.field_overflow;
    assign s_req.ready = ~r_vld & ~r_pend;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = raw[k] * $signed({1'b0, {1'b0, r_adj[k]} + 9'd128});
            quo[k] = prod[k] >>> 8;
            if (prod[k] < 0 && prod[k][7:0] != 8'd0) quo[k] = quo[k] + 26'sd1;
            if (quo[k] > 26'sd32767) n_sc[k] = 16'sh7fff;
            else if (quo[k] < -26'sd32768) n_sc[k] = 16'sh8000;
            else n_sc[k] = quo[k][15:0];
        end
        for (int k = 0; k < 2; k++) begin
            rng[k] = 17'(r_max[k]) - 17'(r_min[k]);
            off[k] = 17'(r_kept[k]) - 17'(r_min[k]);
            numw[k] = off[k] * $signed({1'b0, SPAN_Q8});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_adj[k] <= 8'd128;
                r_kept[k] <= '0;
                r_max[k] <= '0;
                r_min[k] <= '0;
            end
            r_vld <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx != 2'd3) r_adj[i_cfg_idx] <= i_cfg_data;
            if (s_req.valid && s_req.ready) begin
                r_vld <= 1'b1;
                r_cmd <= s_req.data.cmd;
                r_tk <= take;
                if (take) for (int k = 0; k < 3; k++) r_kept[k] <= n_sc[k];
            end
            if (r_vld) begin
                r_vld <= 1'b0;
                r_pend <= 1'b1;
                if (r_cmd == CMD_CAL) begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_kept[k] > r_max[k]) r_max[k] <= r_kept[k];
                        if (r_kept[k] < r_min[k]) r_min[k] <= r_kept[k];
                    end
                end
                r_job.cmd <= r_cmd;
                r_job.taken <= r_tk;
                r_job.fault <= (r_cmd == CMD_REF || r_cmd == CMD_HDG) &&
                               (rng[0] == 17'sd0 || rng[1] == 17'sd0);
                r_job.num_x <= numw[0];
                r_job.num_y <= numw[1];
                r_job.rng_x <= rng[0];
                r_job.rng_y <= rng[1];
            end
            if (r_pend && i_job_ready) r_pend <= 1'b0;
        end
    end
    assign o_job_valid = r_pend;
    assign o_job = r_job;
endmodule
`default_nettype wire

@@ hw/rtl/mhc_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on mhc_pkg; includes assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mhc_queue import mhc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  t_job      i_wr_data,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_job      o_rd_data
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;
    assign o_wr_ready = r_cnt != 2'd2;
    assign o_rd_valid = r_cnt != 2'd0;
    assign wr = i_wr_valid & o_wr_ready;
    assign rd = o_rd_valid & i_rd_ready;
    assign o_rd_data = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) begin r_mem[r_wp] <= i_wr_data; r_wp <= ~r_wp; end
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
    `CHK_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `CHK_NEXT(a_q_fill, i_clk, i_rst_n, wr && !rd, r_cnt == $past(r_cnt) + 2'd1)
endmodule
`default_nettype wire

@@ hw/rtl/mhc_back.sv @@
// Back part: two restoring divisions, CORDIC vectoring, reference and output register.
// Depends on mhc_pkg and mhc_stream_if; includes assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mhc_back import mhc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    mhc_stream_if.source m_rsp
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_PRE = 3'd2,
                           S_ROT = 3'd3, S_FIN = 3'd4, S_OUT = 3'd5;
    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic [2:0] r_st;
    t_job r_job;
    logic r_axis;
    logic [5:0] r_cnt;
    logic [16:0] r_rem;
    logic [35:0] r_quo;
    logic r_neg;
    logic signed [36:0] r_mx, r_my;
    logic signed [39:0] r_vx, r_vy;
    logic signed [31:0] r_z;
    logic signed [15:0] r_ref;
    t_rsp r_rsp;
    logic r_ovld;

    logic [17:0] trial;
    logic [35:0] shn;
    logic signed [36:0] qs;
    logic signed [39:0] dx, dy;
    logic signed [31:0] ang32;
    logic signed [17:0] diff;
    logic signed [17:0] dw;

    assign trial = {r_rem, shn[35]} - {1'b0, r_axis ? r_job.rng_y : r_job.rng_x};
    assign qs = (r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo})) - MID_Q8;
    assign dx = r_vy >>> r_cnt;
    assign dy = r_vx >>> r_cnt;
    assign ang32 = (r_z + 32'sd128) >>> 8;
    assign diff = 18'($signed(ang32[15:0])) - 18'(r_ref);
    assign shn = r_quo;
    assign o_job_ready = (r_st == S_IDLE) && !r_ovld;
    assign m_rsp.valid = r_ovld;
    assign m_rsp.data = r_rsp;

    always_comb begin
        if (diff < 0) begin
            dw = diff + 18'sd46080;
            if (dw < 0) dw = dw + 18'sd46080;
        end else if (diff >= 18'sd46080) begin
            dw = diff - 18'sd46080;
        end else begin
            dw = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ref <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (r_ovld && m_rsp.ready) r_ovld <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid && o_job_ready) begin
                    r_job <= i_job;
                    r_rsp.heading <= '0;
                    r_rsp.sample_taken <= i_job.taken;
                    r_rsp.div_fault <= i_job.fault;
                    if (i_job.fault || (i_job.cmd != CMD_REF && i_job.cmd != CMD_HDG))
                        r_st <= S_OUT;
                    else begin
                        r_st <= S_DIV;
                        r_axis <= 1'b0;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_neg <= i_job.num_x[36];
                        r_quo <= i_job.num_x[36] ? 36'(-i_job.num_x) : 36'(i_job.num_x);
                    end
                end
                S_DIV: begin
                    if (!trial[17]) r_rem <= trial[16:0];
                    else r_rem <= {r_rem[15:0], shn[35]};
                    r_quo <= {r_quo[34:0], ~trial[17]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd35) r_st <= S_PRE;
                end
                S_PRE: begin
                    if (!r_axis) begin
                        r_mx <= qs;
                        r_axis <= 1'b1;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_neg <= r_job.num_y[36];
                        r_quo <= r_job.num_y[36] ? 36'(-r_job.num_y) : 36'(r_job.num_y);
                        r_st <= S_DIV;
                    end else begin
                        r_my <= qs;
                        r_cnt <= '0;
                        r_st <= S_ROT;
                        if (qs < 0) begin
                            if (r_mx >= 0) begin
                                r_vx <= 40'(r_mx); r_vy <= -40'(qs); r_z <= DEG90_FINE;
                            end else begin
                                r_vx <= -40'(r_mx); r_vy <= 40'(qs); r_z <= -DEG90_FINE;
                            end
                        end else begin
                            r_vx <= 40'(qs); r_vy <= 40'(r_mx); r_z <= '0;
                        end
                        if (qs == 0 && r_mx == 0) r_st <= S_FIN;
                    end
                end
                S_ROT: begin
                    if (r_vy >= 0) begin
                        r_vx <= r_vx + dx; r_vy <= r_vy - dy;
                        r_z <= r_z + atan_fine(r_cnt[4:0]);
                    end else begin
                        r_vx <= r_vx - dx; r_vy <= r_vy + dy;
                        r_z <= r_z - atan_fine(r_cnt[4:0]);
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(NSTEPS - 1)) r_st <= S_FIN;
                end
                S_FIN: begin
                    if (r_job.cmd == CMD_REF) r_ref <= ang32[15:0];
                    else r_rsp.heading <= dw[15:0];
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ovld) begin
                    r_ovld <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
    `CHK_IMPL(a_hdg_range, i_clk, i_rst_n, r_ovld, r_rsp.heading < FULL_TURN)
    `CHK_IMPL(a_fault_zero, i_clk, i_rst_n, r_ovld && r_rsp.div_fault, r_rsp.heading == 16'd0)
endmodule
`default_nettype wire

@@ hw/rtl/magnetometer_heading_calibrator.sv @@
// Top level of the magnetometer heading calibrator.
// Depends on mhc_pkg, mhc_stream_if, mhc_front, mhc_queue, mhc_back.
//  channel  dir  payload
//  s_req    in   cmd, reading_x/y/z, data_ready, field_overflow
//  m_rsp    out  heading, sample_taken, div_fault
//  cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data (adjust_x/y/z)
// Front takes one request at a time and takes no new one until its job is
// handed to a two-entry job queue. Reference and heading commands run two
// 36-step restoring divisions then one CORDIC step per cycle in the back part.
// Calibrate, spare and faulted requests go straight to the output. Synchronous reset.
// A stalled m_rsp holds the result and backs up the queue, then s_req.
`default_nettype none
module magnetometer_heading_calibrator import mhc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    mhc_stream_if.sink      s_req,
    mhc_stream_if.source    m_rsp
);
    logic f_valid, f_ready, b_valid, b_ready;
    t_job f_job, b_job;

    mhc_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .s_req,
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );
    mhc_queue u_queue (
        .i_clk, .i_rst_n, .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_data(f_job),
        .o_rd_valid(b_valid), .i_rd_ready(b_ready), .o_rd_data(b_job)
    );
    mhc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(b_valid), .o_job_ready(b_ready), .i_job(b_job), .m_rsp
    );
endmodule
`default_nettype wire

@@ sim/heading_checker.sv @@
// Checker for the magnetometer heading calibrator: watches the request and
// response channels and the config port, predicts each response and compares.
// Depends on mhc_pkg and mhc_stream_if.
`default_nettype none
module heading_checker import mhc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    mhc_stream_if           req_ch,
    mhc_stream_if           rsp_ch,
    output int              o_mismatches,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam longint ATAN_Q15[STEPS] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57
    };

    logic [7:0]         adj [3];
    logic signed [15:0] kept [3];
    logic signed [15:0] win_max [3];
    logic signed [15:0] win_min [3];
    logic signed [15:0] ref_angle;
    t_rsp               heading_due_q [$];
    int                 errors;

    function automatic logic signed [15:0] scale_reading(input logic signed [15:0] raw,
                                                         input logic [7:0] a);
        int p;
        int q;
        p = int'(raw) * (int'(a) + 128);
        q = p / 256;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic longint map_to_window(input int k);
        longint rng;
        longint num;
        rng = longint'(win_max[k]) - longint'(win_min[k]);
        num = (longint'(kept[k]) - longint'(win_min[k])) * 2046 * 256;
        return num / rng - 1023 * 256;
    endfunction

    // atan2(num, den) in 1/128 degree, vectoring CORDIC
    function automatic int cordic_angle(input longint num, input longint den);
        longint vx;
        longint vy;
        longint z;
        longint t;
        longint dx;
        longint dy;
        vx = den;
        vy = num;
        z = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy; vy = -t; z = 2949120;
            end else begin
                vx = -vy; vy = t; z = -2949120;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx; vy -= dy; z += ATAN_Q15[i];
            end else begin
                vx -= dx; vy += dy; z -= ATAN_Q15[i];
            end
        end
        return int'((z + 128) >>> 8);
    endfunction

    function automatic t_rsp predict_heading(input t_req r);
        t_rsp o;
        int   a;
        int   d;
        o = '0;
        if (r.data_ready && !r.field_overflow) begin
            kept[0] = scale_reading(r.reading_x, adj[0]);
            kept[1] = scale_reading(r.reading_y, adj[1]);
            kept[2] = scale_reading(r.reading_z, adj[2]);
            o.sample_taken = 1'b1;
        end
        if (r.cmd == CMD_CAL) begin
            for (int k = 0; k < 3; k++) begin
                if (kept[k] > win_max[k]) win_max[k] = kept[k];
                if (kept[k] < win_min[k]) win_min[k] = kept[k];
            end
        end else if (r.cmd == CMD_REF || r.cmd == CMD_HDG) begin
            if (win_max[0] == win_min[0] || win_max[1] == win_min[1]) begin
                o.div_fault = 1'b1;
            end else begin
                a = cordic_angle(map_to_window(0), map_to_window(1));
                if (r.cmd == CMD_REF) begin
                    ref_angle = a[15:0];
                end else begin
                    d = (a - int'(ref_angle)) % int'(FULL_TURN);
                    if (d < 0) d += int'(FULL_TURN);
                    o.heading = d[15:0];
                end
            end
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                adj[k] = 8'd128; kept[k] = '0; win_max[k] = '0; win_min[k] = '0;
            end
            ref_angle = '0;
            heading_due_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we && i_cfg_idx < 2'd3) adj[i_cfg_idx] = i_cfg_data;
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                if (heading_due_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response: heading %0d taken %0b fault %0b",
                                 got.heading, got.sample_taken, got.div_fault);
                end else begin
                    want = heading_due_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected heading %0d taken %0b fault %0b, got heading %0d taken %0b fault %0b",
                                     want.heading, want.sample_taken, want.div_fault,
                                     got.heading, got.sample_taken, got.div_fault);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) heading_due_q.push_back(predict_heading(req_ch.data));
        end
        o_mismatches <= errors;
        o_pending <= heading_due_q.size();
    end
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench top for the magnetometer heading calibrator: clock, reset,
// request stimulus, response back-pressure, config writes and the verdict.
// Depends on mhc_pkg, mhc_stream_if, heading_checker and the block.
`default_nettype none
module tb import mhc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_ADJ_X = 2'd0;
    localparam logic [1:0] REG_ADJ_Y = 2'd1;
    localparam logic [1:0] REG_ADJ_Z = 2'd2;
    localparam logic [1:0] REG_NONE  = 2'd3;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int WATCHDOG = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;
    int         mismatches;
    int         pending;
    int         send_idle = 0;
    int         recv_stall = 0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    mhc_stream_if #(.T(t_req)) req_if (i_clk);
    mhc_stream_if #(.T(t_rsp)) rsp_if (i_clk);

    magnetometer_heading_calibrator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .s_req(req_if), .m_rsp(rsp_if)
    );

    heading_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .req_ch(req_if), .rsp_ch(rsp_if),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
    end

    // response side back-pressure, with one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            rsp_if.ready <= 1'b0;
            hold_left++;
            if (hold_left >= 400) hold_done = 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic t_req mk(input logic [1:0] c, input int x, input int y, input int z,
                                input bit rdy, input bit ovf);
        t_req r;
        r.cmd = c;
        r.reading_x = x[15:0];
        r.reading_y = y[15:0];
        r.reading_z = z[15:0];
        r.data_ready = rdy;
        r.field_overflow = ovf;
        return r;
    endfunction

    function automatic int rand_axis();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 600)) - 300;
            2: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    task automatic send(input t_req r);
        while ($urandom_range(0, 99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_run(input int n);
        int  pick;
        bit  rdy;
        bit  ovf;
        logic [1:0] c;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            c = pick < 40 ? CMD_CAL : pick < 60 ? CMD_REF : pick < 95 ? CMD_HDG : CMD_SPARE;
            rdy = $urandom_range(0, 99) < 85;
            ovf = $urandom_range(0, 99) < 10;
            send(mk(c, rand_axis(), rand_axis(), rand_axis(), rdy, ovf));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: faults before any window, midpoint, extremes, quadrants
        send(mk(CMD_HDG, 1000, -1000, 7, 1, 0));
        send(mk(CMD_REF, 5, 5, 5, 1, 0));
        send(mk(CMD_CAL, 100, 100, 100, 1, 0));
        send(mk(CMD_HDG, 50, 50, 50, 1, 0));
        send(mk(CMD_CAL, 32767, 32767, 32767, 1, 0));
        send(mk(CMD_CAL, -32768, -32768, -32768, 1, 0));
        send(mk(CMD_SPARE, 0, 0, 0, 1, 0));
        send(mk(CMD_HDG, 0, 0, 0, 0, 0));
        send(mk(CMD_REF, 300, 300, 300, 1, 1));
        send(mk(CMD_HDG, 1000, -2000, 5, 1, 0));
        send(mk(CMD_HDG, -1, -1, -1, 0, 1));
        send(mk(CMD_CAL, 9, 9, 9, 0, 0));
        send(mk(CMD_HDG, 32767, 0, 0, 1, 0));
        send(mk(CMD_HDG, 0, 32767, 0, 1, 0));
        send(mk(CMD_HDG, -32768, 0, 0, 1, 0));
        send(mk(CMD_HDG, 0, -32768, 0, 1, 0));
        send(mk(CMD_REF, -20000, -20000, 1, 1, 0));
        send(mk(CMD_HDG, 20000, -20000, -1, 1, 0));
        send(mk(CMD_HDG, -20000, 20000, 32767, 1, 0));
        send(mk(CMD_SPARE, -32768, 32767, -32768, 1, 1));
        random_run(165);

        for (int ph = 1; ph < 4; ph++) begin
            settle();
            case (ph)
                1: begin
                    write_reg(REG_ADJ_X, 8'd0); write_reg(REG_ADJ_Y, 8'd255);
                    write_reg(REG_ADJ_Z, 8'd0);
                    send_idle = 60; recv_stall = 0;
                end
                2: begin
                    write_reg(REG_ADJ_X, 8'd255); write_reg(REG_ADJ_Y, 8'd0);
                    write_reg(REG_ADJ_Z, 8'd255);
                    send_idle = 0; recv_stall = 60;
                    hold_req = 1'b1;
                end
                default: begin
                    write_reg(REG_ADJ_X, 8'($urandom)); write_reg(REG_ADJ_Y, 8'($urandom));
                    write_reg(REG_ADJ_Z, 8'($urandom)); write_reg(REG_NONE, 8'($urandom));
                    send_idle = 15; recv_stall = 15;
                end
            endcase
            random_run(190);
        end

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ magnetometer_heading_calibrator.f @@
+incdir+hw/rtl
hw/rtl/mhc_pkg.sv
hw/rtl/mhc_stream_if.sv
hw/rtl/mhc_front.sv
hw/rtl/mhc_queue.sv
hw/rtl/mhc_back.sv
hw/rtl/magnetometer_heading_calibrator.sv
sim/heading_checker.sv
sim/tb.sv
